>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// An implication checked in the same cycle.
`define ASSERT_IMPLIES(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/sisr_pkg.sv
// ----------------------------------------------------------------------------
// sisr_pkg
// Shared types and constants of the stable insertion sort block.
// ----------------------------------------------------------------------------
package sisr_pkg;

  localparam int unsigned DEF_MAX_RECORDS = 64;

  // One stored record: identifier and Q16.16 score.
  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] score;
  } rec_t;

  // Memory port strobes issued by the controller.
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_EMIT
  } state_e;

endpackage

>>> sv/sisr_mem.sv
// ----------------------------------------------------------------------------
// sisr_mem
// Record table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sisr_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic              clk_i,
  input  sisr_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]     waddr_i,
  input  sisr_pkg::rec_t    wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output sisr_pkg::rec_t    rdata_o
);
  import sisr_pkg::*;

  rec_t mem_q [DEPTH];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read strobe.
  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/sisr_ctrl.sv
// ----------------------------------------------------------------------------
// sisr_ctrl
// Sequencer for insertion (read, compare, shift up) and sorted read-out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sisr_ctrl #(
  parameter int unsigned MAX_RECORDS = 64,
  parameter int unsigned AW          = 6,
  parameter int unsigned CW          = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sisr_pkg::rec_t     in_rec_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               out_last_o,
  output logic               overflow_o,
  output sisr_pkg::mem_ctl_t mem_ctl_o,
  output logic [AW-1:0]      waddr_o,
  output sisr_pkg::rec_t     wdata_o,
  output logic [AW-1:0]      raddr_o,
  input  sisr_pkg::rec_t     rdata_i
);
  import sisr_pkg::*;

  state_e        state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic          drop_q, drop_d;
  logic [AW-1:0] pos_q, pos_d;
  rec_t          new_q, new_d;
  logic          last_q, last_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          ovalid_q, ovalid_d;
  logic          olast_q, olast_d;
  logic          ovf_q, ovf_d;

  logic          accept;
  logic          full;
  logic          shift;
  logic          emit_rd;
  logic          emit_end;
  logic [CW-1:0] fill_m1;
  logic [CW-1:0] idx_p1;

  assign in_ready_o = (state_q == ST_IDLE) && (!ovalid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign full       = (fill_q == CW'(MAX_RECORDS));
  assign fill_m1    = fill_q - CW'(1);
  assign idx_p1     = idx_q + CW'(1);
  // The stored record at pos-1 moves up while its score is strictly greater.
  assign shift      = (pos_q != '0) && (rdata_i.score > new_q.score);
  assign emit_rd    = (state_q == ST_EMIT) && (!ovalid_q || out_ready_i);
  assign emit_end   = emit_rd && (idx_p1 == fill_q);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (full || fill_q == '0) begin
            state_d = last_i ? ST_EMIT : ST_IDLE;
          end else begin
            state_d = ST_INSERT;
          end
        end
      end
      ST_INSERT: begin
        if (!shift) begin
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (emit_end) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory strobes.
  always_comb begin
    fill_d    = fill_q;
    drop_d    = drop_q;
    pos_d     = pos_q;
    new_d     = new_q;
    last_d    = last_q;
    idx_d     = idx_q;
    olast_d   = olast_q;
    ovf_d     = ovf_q;
    mem_ctl_o = '0;
    waddr_o   = pos_q;
    wdata_o   = new_q;
    raddr_o   = pos_q - AW'(2);

    if (ovalid_q && out_ready_i) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end

    case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (accept) begin
          new_d  = in_rec_i;
          last_d = last_i;
          if (full) begin
            drop_d = 1'b1;
          end else if (fill_q == '0) begin
            mem_ctl_o.we = 1'b1;
            waddr_o      = '0;
            wdata_o      = in_rec_i;
            fill_d       = CW'(1);
          end else begin
            mem_ctl_o.re = 1'b1;
            raddr_o      = fill_m1[AW-1:0];
            pos_d        = fill_q[AW-1:0];
          end
        end
      end
      ST_INSERT: begin
        mem_ctl_o.we = 1'b1;
        if (shift) begin
          wdata_o      = rdata_i;
          pos_d        = pos_q - AW'(1);
          // At position one the next slot is the bottom and needs no compare.
          mem_ctl_o.re = (pos_q > AW'(1));
        end else begin
          fill_d = fill_q + CW'(1);
        end
      end
      ST_EMIT: begin
        if (emit_rd) begin
          mem_ctl_o.re = 1'b1;
          raddr_o      = idx_q[AW-1:0];
          idx_d        = idx_p1;
          olast_d      = (idx_p1 == fill_q);
          ovf_d        = drop_q;
          ovalid_d     = 1'b1;
        end
        if (emit_end) begin
          fill_d = '0;
          drop_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      fill_q   <= '0;
      drop_q   <= 1'b0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      drop_q   <= drop_d;
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    new_q   <= new_d;
    last_q  <= last_d;
    olast_q <= olast_d;
    ovf_q   <= ovf_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_last_o  = olast_q;
  assign overflow_o  = ovf_q;

  `ASSERT_IMPLIES(a_no_rw_same_entry, clk_i, rst_ni, mem_ctl_o.we && mem_ctl_o.re, waddr_o != raddr_o)
  `ASSERT_ALWAYS(a_fill_in_range, clk_i, rst_ni, fill_q <= CW'(MAX_RECORDS))
  `ASSERT_IMPLIES(a_no_read_while_stalled, clk_i, rst_ni, ovalid_q && !out_ready_i, !mem_ctl_o.re)
  `ASSERT_IMPLIES(a_emit_not_empty, clk_i, rst_ni, state_q == ST_EMIT, fill_q != '0)

endmodule

>>> sv/stable_insertion_sort_records.sv
// ----------------------------------------------------------------------------
// stable_insertion_sort_records
// Stable sort of scored records, emitted in ascending score order per batch.
// ----------------------------------------------------------------------------
// Records (key, signed Q16.16 score) are loaded one item at a time into a
// sorted table held in a single-port-read, single-port-write memory. A record
// is written straight into the table when it is empty, or dropped when it is
// full; otherwise the controller walks down from the top of the table, one
// memory read per cycle, moving each stored record with a strictly greater
// score up by one entry. Equal scores keep their arrival order. After the
// record marked last, the table is read out from the bottom through the
// registered read port at one item per cycle while out_ready is high, with
// out_last on the final item and overflow on every item of a batch that
// dropped records beyond capacity. A new record is taken once the read-out
// has finished. No clearing pass is needed after reset.
module stable_insertion_sort_records #(
  parameter int unsigned MAX_RECORDS = sisr_pkg::DEF_MAX_RECORDS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] rec_key_i,
  input  logic signed [31:0] score_i,
  input  logic               last_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_key_o,
  output logic signed [31:0] out_score_o,
  output logic               out_last_o,
  output logic               overflow_o
);
  import sisr_pkg::*;

  localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);

  rec_t          in_rec;
  rec_t          wdata;
  rec_t          rdata;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;

  assign in_rec.key   = rec_key_i;
  assign in_rec.score = score_i;

  sisr_ctrl #(
    .MAX_RECORDS(MAX_RECORDS),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_rec_i   (in_rec),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_last_o (out_last_o),
    .overflow_o (overflow_o),
    .mem_ctl_o  (mem_ctl),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  sisr_mem #(
    .DEPTH(MAX_RECORDS),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .ctl_i  (mem_ctl),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // The memory read register doubles as the output register.
  assign out_key_o   = rdata.key;
  assign out_score_o = rdata.score;

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stable insertion sort of scored records.
// ----------------------------------------------------------------------------
// A short table of hand-picked records exercises signed score extremes, ties
// and single-record batches. Random batches follow: mostly small ones, plus
// batches at and beyond capacity. Each accepted record is fed to a local
// sorting model, and every sorted item that leaves the block is compared with
// the oldest prediction. Both handshakes are throttled in three pacing modes.
// One long receiver stall forces the block to back-pressure its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import sisr_pkg::*;

  localparam int unsigned CAPACITY     = DEF_MAX_RECORDS;
  localparam int unsigned NUM_DIRECTED = 24;
  localparam int unsigned PHASE_ITEMS  = 160;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 2 * CAPACITY + 16;

  typedef struct packed {
    rec_t rec;
    logic last;
    logic ovf;
  } sorted_item_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] score;
    logic               last;
    logic               typed;
    sorted_item_t       exp;
  } sort_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] rec_key_i = '0;
  logic signed [31:0] score_i = '0;
  logic               last_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] out_key_o;
  logic signed [31:0] out_score_o;
  logic               out_last_o;
  logic               overflow_o;

  stable_insertion_sort_records u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rec_key_i   (rec_key_i),
    .score_i     (score_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_key_o   (out_key_o),
    .out_score_o (out_score_o),
    .out_last_o  (out_last_o),
    .overflow_o  (overflow_o)
  );

  always #2 clk_i = ~clk_i;

  // Local copy of the sorted table and its batch status.
  rec_t         sorted_tbl [CAPACITY];
  int unsigned  tbl_fill = 0;
  logic         tbl_dropped = 1'b0;
  sorted_item_t batch_out_q[$];
  sorted_item_t sorted_exp_q[$];

  sort_row_t    dir_rows [NUM_DIRECTED];

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_idle_pct = 0;
  int unsigned  hold_requests = 0;
  int unsigned  hold_served = 0;
  int unsigned  errors = 0;
  int unsigned  records_in = 0;
  int unsigned  batches_in = 0;
  int unsigned  full_batches = 0;
  int unsigned  items_out = 0;

  // Stable insertion: a new record goes after every stored record whose
  // score is less than or equal to its own. A record is lost when full.
  function automatic void predict_sort(logic signed [31:0] key, logic signed [31:0] score,
                                       logic last);
    int unsigned pos;
    batch_out_q.delete();
    if (tbl_fill >= CAPACITY) begin
      tbl_dropped = 1'b1;
    end else begin
      pos = tbl_fill;
      while (pos > 0 && $signed(sorted_tbl[pos - 1].score) > $signed(score)) begin
        sorted_tbl[pos] = sorted_tbl[pos - 1];
        pos--;
      end
      sorted_tbl[pos] = '{key, score};
      tbl_fill++;
    end
    if (last) begin
      for (int unsigned k = 0; k < tbl_fill; k++) begin
        batch_out_q.push_back('{sorted_tbl[k], (k + 1 == tbl_fill) ? 1'b1 : 1'b0,
                                tbl_dropped});
      end
      batches_in++;
      if (tbl_dropped) begin
        full_batches++;
      end
      tbl_fill = 0;
      tbl_dropped = 1'b0;
    end
  endfunction

  // Offers one record, waits for it to be taken and queues what it causes.
  // A typed expectation replaces the model's output for that record.
  task automatic offer_record(logic signed [31:0] key, logic signed [31:0] score,
                              logic last, logic typed, sorted_item_t typed_exp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rec_key_i  <= key;
    score_i    <= score;
    last_i     <= last;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    records_in++;
    predict_sort(key, score, last);
    if (typed) begin
      sorted_exp_q.push_back(typed_exp);
    end else begin
      foreach (batch_out_q[i]) begin
        sorted_exp_q.push_back(batch_out_q[i]);
      end
    end
  endtask

  // Random batches under one pacing mode. The first batch has a forced size
  // so that every mode sees the table at or beyond capacity.
  task automatic run_phase(int unsigned send_pct, int unsigned recv_pct,
                           int unsigned first_size);
    int unsigned        sent;
    int unsigned        size;
    int unsigned        pick;
    logic signed [31:0] sc;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    size = first_size;
    while (sent < PHASE_ITEMS) begin
      for (int unsigned i = 0; i < size; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
          sc = $urandom;
        end else if (pick < 8) begin
          // Few distinct values, so ties are common.
          sc = (int'($urandom_range(0, 6)) - 3) * 65536;
        end else if (pick == 8) begin
          sc = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        end else begin
          sc = int'($urandom_range(0, 2)) - 1;
        end
        offer_record($urandom, sc, (i + 1 == size), 1'b0, '0);
        sent++;
      end
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        size = $urandom_range(1, 10);
      end else if (pick < 95) begin
        size = $urandom_range(11, 30);
      end else begin
        size = $urandom_range(CAPACITY - 4, CAPACITY + 4);
      end
    end
    in_valid_i <= 1'b0;
    while (sorted_exp_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // Receiver: checks each accepted item, then decides the next ready.
  initial begin
    sorted_item_t got;
    sorted_item_t want;
    int unsigned  hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = '{'{out_key_o, out_score_o}, out_last_o, overflow_o};
        items_out++;
        if (sorted_exp_q.size() == 0) begin
          $display("%0t: unexpected item key=%h score=%h last=%b overflow=%b", $time,
                   got.rec.key, got.rec.score, got.last, got.ovf);
          errors++;
        end else begin
          want = sorted_exp_q.pop_front();
          if (got.rec.key !== want.rec.key) begin
            $display("%0t: out_key expected %h actual %h", $time, want.rec.key, got.rec.key);
            errors++;
          end
          if (got.rec.score !== want.rec.score) begin
            $display("%0t: out_score expected %h actual %h", $time, want.rec.score,
                     got.rec.score);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: out_last expected %b actual %b", $time, want.last, got.last);
            errors++;
          end
          if (got.ovf !== want.ovf) begin
            $display("%0t: overflow expected %b actual %b", $time, want.ovf, got.ovf);
            errors++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (hold_served != hold_requests && out_valid_o) begin
        hold_served++;
        hold_left = HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    // Rows 0-3 and 22-23 are single-record batches, so the one sorted item
    // is the record itself. The other rows rely on the local model.
    dir_rows[0]  = '{32'sh7fffffff, 32'sh7fffffff, 1'b1, 1'b1,
                     '{'{32'sh7fffffff, 32'sh7fffffff}, 1'b1, 1'b0}};
    dir_rows[1]  = '{32'sh80000000, 32'sh80000000, 1'b1, 1'b1,
                     '{'{32'sh80000000, 32'sh80000000}, 1'b1, 1'b0}};
    dir_rows[2]  = '{32'sh00000000, 32'sh00000000, 1'b1, 1'b1,
                     '{'{32'sh00000000, 32'sh00000000}, 1'b1, 1'b0}};
    dir_rows[3]  = '{32'shffffffff, 32'shffffffff, 1'b1, 1'b1,
                     '{'{32'shffffffff, 32'shffffffff}, 1'b1, 1'b0}};
    // Equal scores must keep their arrival order.
    dir_rows[4]  = '{32'sh00000010, 32'sh00050000, 1'b0, 1'b0, '0};
    dir_rows[5]  = '{32'sh00000011, 32'sh00050000, 1'b0, 1'b0, '0};
    dir_rows[6]  = '{32'sh00000012, 32'shfffd0000, 1'b0, 1'b0, '0};
    dir_rows[7]  = '{32'sh00000013, 32'sh00050000, 1'b1, 1'b0, '0};
    // Descending arrival across the sign boundary: every record shifts.
    dir_rows[8]  = '{32'sh00000020, 32'sh7fffffff, 1'b0, 1'b0, '0};
    dir_rows[9]  = '{32'sh00000021, 32'sh00000001, 1'b0, 1'b0, '0};
    dir_rows[10] = '{32'sh00000022, 32'sh00000000, 1'b0, 1'b0, '0};
    dir_rows[11] = '{32'sh00000023, 32'shffffffff, 1'b0, 1'b0, '0};
    dir_rows[12] = '{32'sh00000024, 32'sh80000000, 1'b1, 1'b0, '0};
    // Ascending arrival: no record moves.
    dir_rows[13] = '{32'sh00000030, 32'sh80000000, 1'b0, 1'b0, '0};
    dir_rows[14] = '{32'sh00000031, 32'sh80000001, 1'b0, 1'b0, '0};
    dir_rows[15] = '{32'sh00000032, 32'sh00008000, 1'b0, 1'b0, '0};
    dir_rows[16] = '{32'sh00000033, 32'sh7ffffffe, 1'b1, 1'b0, '0};
    // Ties on both extremes, mixed order.
    dir_rows[17] = '{32'shaaaaaaaa, 32'sh7fffffff, 1'b0, 1'b0, '0};
    dir_rows[18] = '{32'sh55555555, 32'sh80000000, 1'b0, 1'b0, '0};
    dir_rows[19] = '{32'sh0f0f0f0f, 32'sh7fffffff, 1'b0, 1'b0, '0};
    dir_rows[20] = '{32'shf0f0f0f0, 32'sh80000000, 1'b0, 1'b0, '0};
    dir_rows[21] = '{32'sh12345678, 32'sh00010000, 1'b1, 1'b0, '0};
    dir_rows[22] = '{32'sh80000000, 32'sh7fffffff, 1'b1, 1'b1,
                     '{'{32'sh80000000, 32'sh7fffffff}, 1'b1, 1'b0}};
    dir_rows[23] = '{32'sh7fffffff, 32'sh80000000, 1'b1, 1'b1,
                     '{'{32'sh7fffffff, 32'sh80000000}, 1'b1, 1'b0}};

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 9;
    recv_idle_pct = 88;
    for (int unsigned r = 0; r < NUM_DIRECTED; r++) begin
      offer_record(dir_rows[r].key, dir_rows[r].score, dir_rows[r].last,
                   dir_rows[r].typed, dir_rows[r].exp);
    end

    // Exactly full, one beyond with the last record dropped, several beyond.
    run_phase(9, 88, CAPACITY);
    run_phase(88, 9, CAPACITY + 1);
    hold_requests++;
    run_phase(0, 0, CAPACITY + 4);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d records in %0d batches, %0d of them over capacity.", records_in,
             batches_in, full_batches);
    $display("Checked %0d sorted items under three pacing modes and one long output stall.",
             items_out);
    if (errors == 0 && sorted_exp_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
